// File: rtl/smeu_pkg.sv
// Shared types and constants for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none

package smeu_pkg;

	localparam int STACK_DEPTH   = 64;
	localparam int MEM_WORDS     = 256;
	localparam int PROGRAM_WORDS = 1024;

	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W  = $clog2(STACK_DEPTH);
	localparam int MADDR_W = $clog2(MEM_WORDS);
	localparam int PC_W    = $clog2(PROGRAM_WORDS);
	localparam int WORD_W  = 32;

	typedef enum logic [3:0] {
		OP_RET = 4'd0,
		OP_JMP = 4'd1,
		OP_BR  = 4'd2,
		OP_LDC = 4'd3,
		OP_ST  = 4'd4,
		OP_LD  = 4'd5,
		OP_ADD = 4'd6,
		OP_SUB = 4'd7,
		OP_CMP = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_END_VALUE = 3'd1,
		ST_END_EMPTY = 3'd2,
		ST_UNDER     = 3'd3,
		ST_OVER      = 3'd4,
		ST_HALTED    = 3'd5
	} status_t;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] constant;
		logic [7:0]         mem_address;
		logic [9:0]         jump_target;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [6:0]         stack_depth;
		logic               branch_taken;
		logic [9:0]         branch_target;
		logic [2:0]         status;
	} out_item_t;

	// stack update requested by the execute logic
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [WORD_W-1:0] data;
	} stk_op_t;

	// cached view of the stack
	typedef struct packed {
		logic [SP_W-1:0]   sp;
		logic [WORD_W-1:0] top;
		logic [WORD_W-1:0] next;
		logic [WORD_W-1:0] third;
	} stk_view_t;

	typedef struct packed {
		logic               en;
		logic [MADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
	} dm_wr_t;

endpackage

`default_nettype wire

// File: rtl/smeu_data_mem.sv
// Zero-initialized data memory with per-word valid bits and write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module smeu_data_mem (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           rd_en,
	input  wire [smeu_pkg::MADDR_W-1:0]   rd_addr,
	input  smeu_pkg::dm_wr_t              wr,
	output logic [smeu_pkg::WORD_W-1:0]   rd_data
);
	import smeu_pkg::*;

	logic [WORD_W-1:0]    mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;
	logic [WORD_W-1:0]    rd_q;
	logic                 rd_vld_q;
	logic                 fwd;

	assign fwd = wr.en && (wr.addr == rd_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q     <= fwd ? wr.data : mem[rd_addr];
			rd_vld_q <= fwd | vld_q[rd_addr];
		end
	end

	// never-written words read as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: rtl/smeu_stack.sv
// Operand stack: top two entries in registers, deeper entries in a spill memory.
`timescale 1ns / 1ps
`default_nettype none

module smeu_stack (
	input  wire                 clk,
	input  wire                 arst_n,
	input  smeu_pkg::stk_op_t   op,
	output smeu_pkg::stk_view_t view
);
	import smeu_pkg::*;

	logic [WORD_W-1:0] smem [STACK_DEPTH];
	logic [SP_W-1:0]   sp_q;
	logic [SP_W-1:0]   sp_n;
	logic [WORD_W-1:0] top_q;
	logic [WORD_W-1:0] next_q;
	logic [WORD_W-1:0] third_q;
	logic [SP_W-1:0]   waddr_full;
	logic [SP_W-1:0]   raddr_full;
	logic [SIDX_W-1:0] waddr;
	logic [SIDX_W-1:0] raddr;
	logic              wen;

	always_comb begin
		sp_n = sp_q;
		if (op.push) begin
			sp_n = sp_q + SP_W'(1);
		end else if (op.pop) begin
			sp_n = sp_q - SP_W'(1);
		end
	end

	// next_q spills to memory entry sp-2 on a push
	assign wen        = op.push && (sp_q >= SP_W'(2));
	assign waddr_full = sp_q - SP_W'(2);
	assign waddr      = waddr_full[SIDX_W-1:0];
	// third_q tracks entry sp-3 of the coming pointer
	assign raddr_full = sp_n - SP_W'(3);
	assign raddr      = raddr_full[SIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			sp_q <= sp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q  <= op.data;
			next_q <= top_q;
		end else if (op.pop) begin
			top_q  <= next_q;
			next_q <= third_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			smem[waddr] <= next_q;
		end
		third_q <= (wen && (waddr == raddr)) ? next_q : smem[raddr];
	end

	assign view = '{sp: sp_q, top: top_q, next: next_q, third: third_q};

endmodule

`default_nettype wire

// File: rtl/smeu_exec.sv
// Instruction decode and execute: stack, memory and branch updates plus the result.
`timescale 1ns / 1ps
`default_nettype none

module smeu_exec (
	input  smeu_pkg::in_item_t          item,
	input  smeu_pkg::stk_view_t         view,
	input  wire                         halted,
	input  wire [smeu_pkg::WORD_W-1:0]  dm_rd,
	output smeu_pkg::stk_op_t           stk_op,
	output smeu_pkg::dm_wr_t            dm_wr,
	output logic                        halt_set,
	output smeu_pkg::out_item_t         result
);
	import smeu_pkg::*;

	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] sign;
	logic [WORD_W-1:0] ret_value;
	logic              ret_set;
	logic [WORD_W-1:0] top_after;
	logic [SP_W-1:0]   sp_after;
	status_t           status;
	logic              taken;
	logic              full;

	assign sum  = view.top + view.next;
	assign diff = view.top - view.next;
	assign full = view.sp >= SP_W'(STACK_DEPTH);

	always_comb begin
		if ($signed(view.top) > $signed(view.next)) begin
			sign = WORD_W'(1);
		end else if ($signed(view.top) < $signed(view.next)) begin
			sign = '1;
		end else begin
			sign = '0;
		end
	end

	always_comb begin
		stk_op    = '0;
		dm_wr     = '0;
		halt_set  = 1'b0;
		status    = ST_OK;
		taken     = 1'b0;
		ret_set   = 1'b0;
		ret_value = '0;
		dm_wr.addr = item.mem_address[MADDR_W-1:0];
		dm_wr.data = view.top;
		if (halted) begin
			status = ST_HALTED;
		end else begin
			case (cmd_t'(item.command))
				OP_RET: begin
					halt_set = 1'b1;
					ret_set  = 1'b1;
					if (view.sp != '0) begin
						stk_op.pop = 1'b1;
						ret_value  = view.top;
						status     = ST_END_VALUE;
					end else begin
						status = ST_END_EMPTY;
					end
				end
				OP_JMP: begin
					taken = 1'b1;
				end
				OP_BR: begin
					taken = (view.sp != '0) && (view.top != '0);
				end
				OP_LDC, OP_LD: begin
					if (full) begin
						status = ST_OVER;
					end else begin
						stk_op.push = 1'b1;
						stk_op.data = (cmd_t'(item.command) == OP_LDC) ?
							item.constant : dm_rd;
					end
				end
				OP_ST: begin
					if (view.sp == '0) begin
						status = ST_UNDER;
					end else begin
						stk_op.pop = 1'b1;
						dm_wr.en   = 1'b1;
					end
				end
				OP_ADD, OP_SUB, OP_CMP: begin
					if (view.sp < SP_W'(2)) begin
						status = ST_UNDER;
					end else if (full) begin
						status = ST_OVER;
					end else begin
						stk_op.push = 1'b1;
						case (cmd_t'(item.command))
							OP_ADD:  stk_op.data = sum;
							OP_SUB:  stk_op.data = diff;
							default: stk_op.data = sign;
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sp_after  = view.sp;
		top_after = view.top;
		if (stk_op.push) begin
			sp_after  = view.sp + SP_W'(1);
			top_after = stk_op.data;
		end else if (stk_op.pop) begin
			sp_after  = view.sp - SP_W'(1);
			top_after = view.next;
		end
	end

	always_comb begin
		result.top_value     = ret_set ? ret_value :
			((sp_after == '0) ? '0 : top_after);
		result.stack_depth   = sp_after;
		result.branch_taken  = taken;
		result.branch_target = taken ? item.jump_target[PC_W-1:0] : '0;
		result.status        = status;
	end

endmodule

`default_nettype wire

// File: rtl/stack_machine_execute_unit_top.sv
// Top level of the stack machine execute unit.
//
//   channel   dir  handshake            payload
//   cmd       in   cmd_valid/cmd_stall  cmd_item (command, constant, mem_address, jump_target)
//   res       out  res_valid/res_stall  res_item (top_value, stack_depth, branch_taken,
//                                                 branch_target, status)
//
// One instruction per cycle sustained while res_stall is low. A transfer lands in the input
// register (_s1) together with the data memory read for its address; it then executes
// against the cached stack top/next and loads the result register. Reset clears the
// stack pointer, halt flag and data memory valid bits at once; no clearing pass. A stalled
// result holds the result register, s1 holds, and cmd_stall rises only when s1 is full
// and cannot drain.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_execute_unit_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  smeu_pkg::in_item_t   cmd_item,
	output logic                 res_valid,
	input  wire                  res_stall,
	output smeu_pkg::out_item_t  res_item
);
	import smeu_pkg::*;

	logic      s1_valid_q;
	in_item_t  item_s1;
	logic      exec_en;
	logic      accept;
	logic      halted_q;
	out_item_t res_q;
	logic      res_valid_q;

	logic [WORD_W-1:0] dm_rd;
	dm_wr_t            dm_wr;
	dm_wr_t            dm_wr_gated;
	stk_op_t           stk_op;
	stk_op_t           stk_op_gated;
	stk_view_t         view;
	logic              halt_set;
	out_item_t         result;

	// s1 drains whenever the result register is empty or being taken
	assign exec_en   = s1_valid_q && (!res_valid_q || !res_stall);
	assign cmd_stall = s1_valid_q && !exec_en;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (exec_en) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd_item;
		end
	end

	// state only changes when the s1 instruction actually executes
	assign stk_op_gated = '{push: stk_op.push & exec_en, pop: stk_op.pop & exec_en,
		data: stk_op.data};
	assign dm_wr_gated  = '{en: dm_wr.en & exec_en, addr: dm_wr.addr, data: dm_wr.data};

	// a store executing this cycle is forwarded to a load entering s1
	smeu_data_mem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (cmd_item.mem_address[MADDR_W-1:0]),
		.wr      (dm_wr_gated),
		.rd_data (dm_rd)
	);

	smeu_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (stk_op_gated),
		.view   (view)
	);

	smeu_exec u_exec (
		.item     (item_s1),
		.view     (view),
		.halted   (halted_q),
		.dm_rd    (dm_rd),
		.stk_op   (stk_op),
		.dm_wr    (dm_wr),
		.halt_set (halt_set),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (exec_en && halt_set) begin
			halted_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_en) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

`default_nettype wire

// File: rtl/smeu_checker.sv
// Port-level checks for the stack machine execute unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module smeu_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  res_valid,
	input wire                  res_stall,
	input smeu_pkg::out_item_t  res_item
);
	import smeu_pkg::*;

	logic ended_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (res_valid && !res_stall &&
			(res_item.status inside {ST_END_VALUE, ST_END_EMPTY})) begin
			ended_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	a_after_ret: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ended_q |-> res_item.status == ST_HALTED)
		else $error("result after ret not marked halted");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.stack_depth <= 7'(STACK_DEPTH))
		else $error("stack depth out of range");

	a_no_branch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status != ST_OK |-> !res_item.branch_taken)
		else $error("branch reported with non-ok status");

	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.branch_taken |-> res_item.branch_target == '0)
		else $error("target set on untaken branch");

endmodule

bind stack_machine_execute_unit_top smeu_checker u_smeu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

`default_nettype wire

// File: tb/sv/smeu_scoreboard_pkg.sv
// Scoreboard class for the stack machine execute unit: predicts and checks results.
`timescale 1ns / 1ps

package smeu_scoreboard_pkg;
	import smeu_pkg::*;

	localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

	class exec_ledger;
		// shadow machine state
		logic [31:0] stack_words [STACK_DEPTH];
		logic [31:0] data_words [MEM_WORDS];
		int unsigned depth;
		bit halted;

		out_item_t pending_outcomes [$];

		int mismatches;
		int transfers_in;
		int results_checked;
		int taken_tally;
		int deepest;
		int status_tally [8];

		function new();
			depth = 0;
			halted = 1'b0;
			mismatches = 0;
			transfers_in = 0;
			results_checked = 0;
			taken_tally = 0;
			deepest = 0;
			foreach (data_words[i]) data_words[i] = '0;
			foreach (stack_words[i]) stack_words[i] = '0;
			foreach (status_tally[i]) status_tally[i] = 0;
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		// Run one accepted instruction on the shadow state, queue its outcome.
		function void note_command(in_item_t cmd);
			out_item_t r;
			logic [31:0] a;
			logic [31:0] b;
			logic [31:0] word;
			bit popped;
			r = '0;
			r.status = ST_OK;
			popped = 1'b0;
			if (halted) begin
				r.status = ST_HALTED;
			end else begin
				case (cmd.command)
				OP_RET: begin
					popped = 1'b1;
					if (depth > 0) begin
						depth--;
						r.top_value = stack_words[depth];
						r.status = ST_END_VALUE;
					end else begin
						r.top_value = '0;
						r.status = ST_END_EMPTY;
					end
					halted = 1'b1;
				end
				OP_JMP: begin
					r.branch_taken = 1'b1;
					r.branch_target = cmd.jump_target;
				end
				OP_BR: begin
					if (depth > 0 && stack_words[depth - 1] != '0) begin
						r.branch_taken = 1'b1;
						r.branch_target = cmd.jump_target;
					end
				end
				OP_LDC, OP_LD: begin
					if (depth >= STACK_DEPTH) begin
						r.status = ST_OVER;
					end else begin
						word = (cmd.command == OP_LDC) ? cmd.constant
							: data_words[cmd.mem_address];
						stack_words[depth] = word;
						depth++;
					end
				end
				OP_ST: begin
					if (depth == 0) begin
						r.status = ST_UNDER;
					end else begin
						depth--;
						data_words[cmd.mem_address] = stack_words[depth];
					end
				end
				OP_ADD, OP_SUB, OP_CMP: begin
					if (depth < 2) begin
						r.status = ST_UNDER;
					end else if (depth >= STACK_DEPTH) begin
						r.status = ST_OVER;
					end else begin
						a = stack_words[depth - 1];
						b = stack_words[depth - 2];
						if (cmd.command == OP_ADD)
							word = a + b;
						else if (cmd.command == OP_SUB)
							word = a - b;
						else if ($signed(a) > $signed(b))
							word = 32'd1;
						else if ($signed(a) < $signed(b))
							word = MINUS_ONE;
						else
							word = '0;
						stack_words[depth] = word;
						depth++;
					end
				end
				default: ;
				endcase
			end
			if (!popped)
				r.top_value = (depth > 0) ? stack_words[depth - 1] : '0;
			r.stack_depth = 7'(depth);

			transfers_in++;
			status_tally[r.status]++;
			if (r.branch_taken)
				taken_tally++;
			if (depth > deepest)
				deepest = depth;
			pending_outcomes.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("MISMATCH %0d at %0t: %s", mismatches, $time, what);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_outcomes.size() == 0) begin
				report($sformatf("result with nothing outstanding: %h", got));
				return;
			end
			want = pending_outcomes.pop_front();
			results_checked++;
			if (got.top_value !== want.top_value)
				report($sformatf("result %0d top_value got %h want %h",
					results_checked, got.top_value, want.top_value));
			if (got.stack_depth !== want.stack_depth)
				report($sformatf("result %0d stack_depth got %0d want %0d",
					results_checked, got.stack_depth, want.stack_depth));
			if (got.branch_taken !== want.branch_taken)
				report($sformatf("result %0d branch_taken got %b want %b",
					results_checked, got.branch_taken, want.branch_taken));
			if (got.branch_target !== want.branch_target)
				report($sformatf("result %0d branch_target got %0d want %0d",
					results_checked, got.branch_target, want.branch_target));
			if (got.status !== want.status)
				report($sformatf("result %0d status got %0d want %0d",
					results_checked, got.status, want.status));
		endtask
	endclass

endpackage

// File: tb/sv/tb_stack_machine_execute_unit_top.sv
// Testbench top for the stack machine execute unit: directed and random instruction streams.
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit_top;
	import smeu_pkg::*;
	import smeu_scoreboard_pkg::*;

	localparam int RAND_ITEMS = 500;
	// last stretch of the random part runs with no gaps and no stalls
	localparam int CALM_ITEMS = 60;
	// opcodes the block must treat as no-ops
	localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

	// shape of a random phase: grow the stack, shrink it, or wander
	typedef enum {WALK_FILL, WALK_DRAIN, WALK_MIX} walk_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	in_item_t  cmd_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res_item;

	exec_ledger ledger = new();

	// 1-in-N odds of starting an idle burst; 0 turns idling off
	int send_odds = 0;
	int stall_odds = 0;

	always #6 clk = ~clk;

	stack_machine_execute_unit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// Result side: check every transfer, then decide the stall for the next
	// cycle. Stall bursts are independent of res_valid.
	initial begin : result_side
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				ledger.check_result(res_item);
			if (burst > 0)
				burst--;
			else if (stall_odds > 0 && $urandom_range(1, stall_odds) == 1)
				burst = $urandom_range(1, 6);
			res_stall <= (burst > 0);
		end
	end

	// One instruction transfer. An optional idle burst goes first; valid stays
	// high across back-to-back transfers so it is never dropped and raised in
	// the same step. The shadow model is updated at the accepting edge.
	task automatic issue(input in_item_t it);
		int gap;
		gap = 0;
		if (send_odds > 0 && $urandom_range(1, send_odds) == 1)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		ledger.note_command(it);
	endtask

	task automatic issue_fields(input logic [3:0] command, input logic [31:0] constant,
			input logic [7:0] addr, input logic [9:0] target);
		in_item_t it;
		it.command = command;
		it.constant = constant;
		it.mem_address = addr;
		it.jump_target = target;
		issue(it);
	endtask

	// Hold off the sender until every outstanding result has been checked.
	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (ledger.pending() > 0);
	endtask

	// Operand mix: sign/magnitude extremes, tiny values so compares hit
	// equality, and plain random words.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return $urandom_range(0, 6) - 3;
		3: return '0;
		4: return MINUS_ONE;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] pick_arith();
		case ($urandom_range(0, 2))
		0: return OP_ADD;
		1: return OP_SUB;
		default: return OP_CMP;
		endcase
	endfunction

	// Weighted opcode choice. Control flow and unused opcodes show up in every
	// phase; the push/pop balance depends on the walk so the stack reaches
	// both empty and full.
	function automatic logic [3:0] pick_command(walk_t walk);
		int roll;
		int push_pct;
		int arith_pct;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		if (roll < 12)
			return OP_BR;
		if (roll < 16)
			return OP_JMP;
		case (walk)
		WALK_FILL: begin
			push_pct = 55;
			arith_pct = 35;
		end
		WALK_DRAIN: begin
			push_pct = 15;
			arith_pct = 10;
		end
		default: begin
			push_pct = 30;
			arith_pct = 20;
		end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return ($urandom_range(0, 2) == 0) ? OP_LD : OP_LDC;
		if (roll < push_pct + arith_pct)
			return pick_arith();
		return OP_ST;
	endfunction

	function automatic in_item_t random_item(walk_t walk);
		in_item_t it;
		it.command = pick_command(walk);
		it.constant = pick_word();
		// half the addresses come from a small window so loads see stored data
		it.mem_address = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
			: 8'($urandom);
		it.jump_target = 10'($urandom);
		return it;
	endfunction

	// Directed opening: empty-stack corner cases first, then arithmetic on
	// extreme operands, all three compare outcomes, branch both ways, jumps,
	// store/load round trip, and unused opcodes.
	task automatic run_directed();
		issue_fields(OP_BR, pick_word(), 8'd0, 10'd5);             // empty: falls through
		issue_fields(OP_ST, pick_word(), 8'd0, 10'd0);             // underflow
		issue_fields(OP_ADD, pick_word(), 8'd0, 10'd0);            // underflow, empty
		issue_fields(OP_LD, pick_word(), 8'd255, 10'd0);           // untouched word reads 0
		issue_fields(OP_SUB, pick_word(), 8'd0, 10'd0);            // underflow, one entry
		issue_fields(OP_BR, pick_word(), 8'd0, 10'd1023);          // top zero: not taken
		issue_fields(OP_LDC, 32'h7FFF_FFFF, 8'd0, 10'd0);
		issue_fields(OP_CMP, pick_word(), 8'd0, 10'd0);            // greater
		issue_fields(OP_SUB, pick_word(), 8'd0, 10'd0);
		issue_fields(OP_LDC, 32'h8000_0000, 8'd0, 10'd0);
		issue_fields(OP_ADD, pick_word(), 8'd0, 10'd0);            // wraps
		issue_fields(OP_LDC, 32'h8000_0000, 8'd0, 10'd0);
		issue_fields(OP_LDC, MINUS_ONE, 8'd0, 10'd0);
		issue_fields(OP_CMP, pick_word(), 8'd0, 10'd0);            // signed: -1 > min
		issue_fields(OP_LDC, 32'd5, 8'd0, 10'd0);
		issue_fields(OP_LDC, 32'd5, 8'd0, 10'd0);
		issue_fields(OP_CMP, pick_word(), 8'd0, 10'd0);            // equal
		issue_fields(OP_LDC, 32'hFFFF_FFFD, 8'd0, 10'd0);
		issue_fields(OP_CMP, pick_word(), 8'd0, 10'd0);            // less
		issue_fields(OP_BR, pick_word(), 8'd0, 10'd1023);          // nonzero top: taken
		issue_fields(OP_JMP, pick_word(), 8'd0, 10'd0);
		issue_fields(OP_ST, pick_word(), 8'd255, 10'd0);
		issue_fields(OP_LD, pick_word(), 8'd255, 10'd0);           // reads back the store
		issue_fields(CMD_UNUSED_LO, pick_word(), 8'd0, 10'd0);
		issue_fields(CMD_UNUSED_HI, pick_word(), 8'd0, 10'd0);
	endtask

	// Ret halts for good and reset is never repeated, so it comes last. The
	// seed decides whether the program ends on an empty stack or with a
	// value; afterwards every opcode must be ignored.
	task automatic finish_program();
		logic [3:0] after_halt [6];
		after_halt = '{OP_LDC, OP_ST, OP_ADD, OP_JMP, OP_BR, OP_RET};
		if ($urandom_range(0, 1) == 0) begin
			while (ledger.depth > 0)
				issue_fields(OP_ST, pick_word(), 8'($urandom), 10'($urandom));
		end else if (ledger.depth == 0) begin
			issue_fields(OP_LDC, pick_word(), 8'd0, 10'd0);
		end
		issue_fields(OP_RET, pick_word(), 8'($urandom), 10'($urandom));
		foreach (after_halt[i])
			issue_fields(after_halt[i], pick_word(), 8'($urandom), 10'($urandom));
	endtask

	initial begin : stimulus
		int sent;
		int span;
		walk_t walk;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_odds = 4;
		stall_odds = 5;
		run_directed();
		// let the pipeline empty completely once before the random part
		wait_for_results();

		// random part in phases; each phase picks a walk and an idling level,
		// level 0 giving stretches with no gaps at all
		sent = 0;
		while (sent < RAND_ITEMS) begin
			walk = walk_t'($urandom_range(0, 2));
			span = $urandom_range(40, 120);
			case ($urandom_range(0, 2))
			0: begin
				send_odds = 0;
				stall_odds = 0;
			end
			1: begin
				send_odds = 3;
				stall_odds = 3;
			end
			default: begin
				send_odds = 6;
				stall_odds = 8;
			end
			endcase
			repeat (span) begin
				if (sent >= RAND_ITEMS)
					break;
				if (sent >= RAND_ITEMS - CALM_ITEMS) begin
					send_odds = 0;
					stall_odds = 0;
				end
				issue(random_item(walk));
				sent++;
			end
		end

		finish_program();
		wait_for_results();
		// spare cycles afterwards catch stray results
		repeat (10) @(posedge clk);

		$display("covered %0d transfers, %0d results, %0d taken branches, peak depth %0d",
			ledger.transfers_in, ledger.results_checked, ledger.taken_tally, ledger.deepest);
		$display("status mix: ok %0d, ended %0d/%0d, underflow %0d, overflow %0d, halted %0d",
			ledger.status_tally[ST_OK], ledger.status_tally[ST_END_VALUE],
			ledger.status_tally[ST_END_EMPTY], ledger.status_tally[ST_UNDER],
			ledger.status_tally[ST_OVER], ledger.status_tally[ST_HALTED]);
		if (ledger.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hang guard: a normal run needs well under a tenth of this.
	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
